// ===== rtl/tat_pkg.sv =====
package tat_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic [WORD_W-1:0] TTL_RESET = 32'd300;

  localparam logic STATUS_ADDED   = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  // One table row: identifier, source address and time stamp.
  typedef struct packed {
    word_t msg_id;
    word_t src_addr;
    word_t stamp;
  } entry_t;

endpackage

// ===== rtl/ttl_aging_id_table.sv =====
// Sequence: an add into a non-full table without a periodic sweep goes from ST_IDLE
// through ST_APPEND to a registered result; each sweep walks every live row through
// ST_SWEEP_RD and ST_SWEEP_CHK and closes in ST_SWEEP_RD. One item at a time, as the
// single table read port and the one age comparator walk the rows.
// Reset (rst_ni low, asynchronous): table empty, add phase zero, max_age = 300,
// no result pending; table rows stay undefined until written.
module ttl_aging_id_table #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned SWEEP_PERIOD = 100
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               max_age_we_i,
  input  tat_pkg::word_t     max_age_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tat_pkg::word_t     message_id_i,
  input  tat_pkg::word_t     source_address_i,
  input  tat_pkg::word_t     now_time_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output tat_pkg::out_cnt_t  entry_count_o,
  output tat_pkg::out_cnt_t  removed_count_o
);
  import tat_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PH_W  = $clog2(SWEEP_PERIOD + 1);

  localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(TABLE_DEPTH);
  localparam logic [PH_W-1:0]  PERIOD_CNT = PH_W'(SWEEP_PERIOD);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP_RD,   // issue read of row scan_q, or close the sweep
    ST_SWEEP_CHK,  // age check on the read row, keep it at kept_q
    ST_APPEND
  } state_e;

  state_e          state_q;
  word_t           ttl_q;
  logic [CNT_W-1:0] live_q;
  logic [CNT_W-1:0] scan_q;
  logic [CNT_W-1:0] kept_q;
  logic [PH_W-1:0]  phase_q;
  logic             pre_sweep_q;  // sweep runs before the append (table was full)
  entry_t           item_q;
  logic             out_valid_q;
  logic             status_q;
  out_cnt_t         removed_q;

  // table port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  logic             row_young;
  logic [PH_W-1:0]  phase_inc;

  tat_mem #(
    .Depth (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Shared age unit: wrapping subtract and compare against the TTL.
  assign row_young = (item_q.stamp - mem_rdata.stamp) <= ttl_q;
  assign phase_inc = phase_q + PH_W'(1);

  // Single write port: append the new row, or move a surviving row down.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = live_q[IDX_W-1:0];
    mem_wdata = item_q;
    case (state_q)
      ST_APPEND: begin
        mem_we = 1'b1;
      end
      ST_SWEEP_CHK: begin
        mem_we    = row_young;
        mem_waddr = kept_q[IDX_W-1:0];
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ttl_q       <= TTL_RESET;
      live_q      <= '0;
      scan_q      <= '0;
      kept_q      <= '0;
      phase_q     <= '0;
      pre_sweep_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_ADDED;
      removed_q   <= '0;
    end else begin
      // user must write config only while idle; the block does not enforce it
      if (max_age_we_i) begin
        ttl_q <= max_age_i;
      end

      // drop the result once transferred
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            item_q.msg_id   <= message_id_i;
            item_q.src_addr <= source_address_i;
            item_q.stamp    <= now_time_i;
            removed_q       <= '0;
            status_q        <= STATUS_ADDED;
            scan_q          <= '0;
            kept_q          <= '0;
            if (live_q == FULL_CNT) begin
              // full table: sweep before trying to append
              pre_sweep_q <= 1'b1;
              state_q     <= ST_SWEEP_RD;
            end else begin
              state_q <= ST_APPEND;
            end
          end
        end

        ST_SWEEP_RD: begin
          if (scan_q == live_q) begin
            // close the sweep: commit the packed count
            live_q    <= kept_q;
            removed_q <= removed_q + OUT_CNT_W'(live_q - kept_q);
            if (pre_sweep_q && (kept_q != FULL_CNT)) begin
              pre_sweep_q <= 1'b0;
              state_q     <= ST_APPEND;
            end else begin
              // still full after the sweep, or periodic sweep done
              if (pre_sweep_q) begin
                status_q <= STATUS_DROPPED;
              end
              pre_sweep_q <= 1'b0;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end else begin
            state_q <= ST_SWEEP_CHK;
          end
        end

        ST_SWEEP_CHK: begin
          if (row_young) begin
            kept_q <= kept_q + CNT_W'(1);
          end
          scan_q  <= scan_q + CNT_W'(1);
          state_q <= ST_SWEEP_RD;
        end

        ST_APPEND: begin
          live_q <= live_q + CNT_W'(1);
          if (phase_inc >= PERIOD_CNT) begin
            // periodic sweep over the table including the new row
            phase_q <= '0;
            scan_q  <= '0;
            kept_q  <= '0;
            state_q <= ST_SWEEP_RD;
          end else begin
            phase_q     <= phase_inc;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign entry_count_o   = OUT_CNT_W'(live_q);
  assign removed_count_o = removed_q;

endmodule

// ===== rtl/tat_mem.sv =====
module tat_mem #(
  parameter int unsigned Depth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(Depth)-1:0]             waddr_i,
  input  tat_pkg::entry_t                      wdata_i,
  input  logic [$clog2(Depth)-1:0]             raddr_i,
  output tat_pkg::entry_t                      rdata_o
);
  import tat_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
